>>> hdl/rms_pkg.sv
package rms_pkg;

  // Largest number of samples counted in one capture block.
  localparam int MAX_FRAMES = 4096;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  // Squares of Q1.15 magnitudes reach 2^30.
  localparam int SQ_W     = 31;
  localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W    = SQ_W + $clog2(MAX_FRAMES);
  // Square root works on a 32-bit radicand, two bits per step.
  localparam int RAD_W    = 32;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int SUB_W    = (CNT_W + 1 > SREM_W + 2) ? CNT_W + 1 : SREM_W + 2;
  localparam int IT_W     = $clog2(SUM_W);

endpackage

>>> hdl/rms_if.sv
interface rms_in_if;
  import rms_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       has_sample;
  logic                       block_end;

  modport source (output valid, output sample, output has_sample, output block_end,
                  input ready);
  modport sink (input valid, input sample, input has_sample, input block_end,
                output ready);
endinterface

interface rms_out_if;
  import rms_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] rms_level;
  logic               samples_dropped;

  modport source (output valid, output rms_level, output samples_dropped, input ready);
  modport sink (input valid, input rms_level, input samples_dropped, output ready);
endinterface

>>> hdl/block_rms_level_meter.sv
// An idle beat is taken in the accept step alone; a counted sample passes accept, square and add.
// A closing beat then passes close, the divide steps, the square root steps and output;
// an empty block goes from close straight to output. The shared subtractor runs
// one restoring divide step per cycle, then one square root step per cycle.
// Throughput: one beat at a time; in_ready is high only while the sequencer waits for input.
// Reset (synchronous, active low) clears the sum, count, drop flag, sequencer and out_valid.
module block_rms_level_meter
  import rms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rms_in_if.sink     in_ch,
  rms_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CLOSE,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                ovf_r;
  logic                end_r;
  logic [SAMPLE_W-1:0] mag_r;
  logic [SQ_W-1:0]     prod_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [RAD_W-1:0]    rad_r;
  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [IT_W-1:0]     it_r;
  logic [LEVEL_W-1:0]  level_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic                out_drop_r;

  logic                in_fire;
  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] square;
  logic [SUB_W-1:0]    sub_a;
  logic [SUB_W-1:0]    sub_b;
  logic [SUB_W:0]      sub_d;
  logic                fits;
  logic                qbit_last;

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign in_fire                = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.rms_level       = out_level_r;
  assign out_ch.samples_dropped = out_drop_r;

  assign mag    = in_ch.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_ch.sample) : in_ch.sample;
  assign square = mag_r * mag_r;

  // One subtractor serves both the divide and the square root steps.
  always_comb begin
    case (state_r)
      ST_DIV: begin
        sub_a = SUB_W'({rem_r, quo_r[SUM_W-1]});
        sub_b = SUB_W'(cnt_r);
      end
      ST_SQRT: begin
        sub_a = SUB_W'({srem_r, rad_r[RAD_W-1 -: 2]});
        sub_b = SUB_W'({root_r, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
  assign fits      = !sub_d[SUB_W];
  assign qbit_last = fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the output step the result register is handled below.
      if (out_valid_r && out_ch.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            end_r <= in_ch.block_end;
            mag_r <= mag;
            if (in_ch.has_sample && (cnt_r < CNT_W'(MAX_FRAMES))) begin
              state_r <= ST_MUL;
            end else begin
              if (in_ch.has_sample) begin
                ovf_r <= 1'b1;
              end
              if (in_ch.block_end) begin
                state_r <= ST_CLOSE;
              end
            end
          end
        end
        ST_MUL: begin
          prod_r  <= square[SQ_W-1:0];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          sum_r   <= sum_r + SUM_W'(prod_r);
          cnt_r   <= cnt_r + 1'b1;
          state_r <= end_r ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          quo_r <= sum_r;
          rem_r <= '0;
          it_r  <= '0;
          if (cnt_r == '0) begin
            level_r <= '0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= fits ? sub_d[CNT_W-1:0] : sub_a[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], qbit_last};
          if (it_r == IT_W'(SUM_W - 1)) begin
            // The mean never passes 2^30, so it fits the radicand.
            rad_r   <= RAD_W'({quo_r[SUM_W-2:0], qbit_last});
            srem_r  <= '0;
            root_r  <= '0;
            it_r    <= '0;
            state_r <= ST_SQRT;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        ST_SQRT: begin
          srem_r <= fits ? sub_d[SREM_W-1:0] : sub_a[SREM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], fits};
          rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
          if (it_r == IT_W'(ROOT_W - 1)) begin
            level_r <= {root_r[ROOT_W-2:0], fits};
            state_r <= ST_OUT;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        ST_OUT: begin
          // Wait for the result register to drain before loading the new level.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_level_r <= level_r;
            out_drop_r  <= ovf_r;
            sum_r       <= '0;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAMES))
    else $error("sample count passed the block limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < cnt_r))
    else $error("divide remainder not below the sample count");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result beat raised outside the output step");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r <= LEVEL_W'(32768)))
    else $error("level above full scale");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_OUT && state_r == ST_IDLE) |-> (cnt_r == '0 && !ovf_r))
    else $error("block state not cleared after a result");

endmodule

>>> tb/rms_level_checker.sv
`timescale 1ns / 1ps

module rms_level_checker
  import rms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rms_in_if    in_ch,
  rms_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               dropped;
  } level_rec_t;

  level_rec_t  level_q[$];
  logic [63:0] energy_sum;
  int unsigned frames;
  logic        dropping;

  // Largest root whose square does not pass v, found one bit at a time from the top.
  function automatic logic [LEVEL_W-1:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = LEVEL_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    level_rec_t want;
    longint     s;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      energy_sum = '0;
      frames     = 0;
      dropping   = 1'b0;
      level_q.delete();
      fail_count <= 0;
    end else begin
      // Results are checked before the input beat of the same edge is predicted,
      // so a result can never be matched against the beat that arrives with it.
      if (out_ch.valid && out_ch.ready) begin
        if (level_q.size() == 0) begin
          $error("result with no expected level: rms_level %0d samples_dropped %0b",
                 out_ch.rms_level, out_ch.samples_dropped);
          errs++;
        end else begin
          want = level_q.pop_front();
          if (out_ch.rms_level !== want.level) begin
            $error("rms_level: expected %0d, actual %0d", want.level, out_ch.rms_level);
            errs++;
          end
          if (out_ch.samples_dropped !== want.dropped) begin
            $error("samples_dropped: expected %0b, actual %0b",
                   want.dropped, out_ch.samples_dropped);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.has_sample) begin
          if (frames < MAX_FRAMES) begin
            s = in_ch.sample;
            energy_sum = energy_sum + 64'(s * s);
            frames++;
          end else begin
            dropping = 1'b1;
          end
        end
        if (in_ch.block_end) begin
          want.level   = (frames == 0) ? '0 : int_sqrt(energy_sum / 64'(frames));
          want.dropped = dropping;
          level_q.push_back(want);
          energy_sum = '0;
          frames     = 0;
          dropping   = 1'b0;
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= level_q.size();
  end

endmodule

>>> tb/tb_block_rms_level_meter.sv
`timescale 1ns / 1ps

module tb_block_rms_level_meter;
  import rms_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int TAIL     = 80;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles  = 0;
  int   counted       = 0;

  rms_in_if  in_ch();
  rms_out_if out_ch();

  block_rms_level_meter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rms_level_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("tb_block_rms_level_meter NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(15))
      0:       s = 16'sh8000;
      1:       s = 16'sh7FFF;
      2:       s = 16'sh0000;
      3:       s = -16'sd1;
      4:       s = 16'sd1;
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Returns right after the edge that accepted the beat; valid stays high so that a
  // back-to-back beat needs no second assignment in the same step.
  task automatic drive_item(input logic signed [SAMPLE_W-1:0] s, input logic hs,
                            input logic be);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.has_sample <= hs;
    in_ch.block_end  <= be;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic random_block();
    int len;
    bit close_on_sample;
    case ($urandom_range(9))
      0:       len = 0;
      8:       len = $urandom_range(9, 40);
      9:       len = $urandom_range(41, 120);
      default: len = $urandom_range(1, 8);
    endcase
    close_on_sample = (len != 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) drive_item(rand_sample(), 1'b0, 1'b0);
      drive_item(rand_sample(), 1'b1, close_on_sample && (i == len - 1));
      counted++;
    end
    if (!close_on_sample) begin
      drive_item(rand_sample(), 1'b0, 1'b1);
      counted++;
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.sample     <= '0;
    in_ch.has_sample <= 1'b0;
    in_ch.block_end  <= 1'b0;
    rst_n            <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty blocks, one of them after an idle beat with a stray sample value.
    drive_item(16'sh0000, 1'b0, 1'b1);
    drive_item(16'sh7FFF, 1'b0, 1'b0);
    drive_item(16'sh8000, 1'b0, 1'b1);
    // Single-sample blocks closed on the sample itself.
    drive_item(16'sh7FFF, 1'b1, 1'b1);
    drive_item(16'sh8000, 1'b1, 1'b1);
    drive_item(16'sh0000, 1'b1, 1'b1);
    // Full-scale negative block closed by an empty beat gives the largest level.
    drive_item(16'sh8000, 1'b1, 1'b0);
    drive_item(16'sh8000, 1'b1, 1'b0);
    drive_item(16'sh8000, 1'b1, 1'b0);
    drive_item(16'sh0000, 1'b0, 1'b1);
    drive_item(16'sd1, 1'b1, 1'b0);
    drive_item(-16'sd1, 1'b1, 1'b1);
    drive_item(16'sh7FFF, 1'b1, 1'b0);
    drive_item(16'sh0000, 1'b1, 1'b0);
    drive_item(16'sh5555, 1'b0, 1'b0);
    drive_item(16'shAAAA, 1'b1, 1'b0);
    drive_item(16'sh8000, 1'b1, 1'b1);
    drive_item(-16'sd2, 1'b1, 1'b0);
    drive_item(16'sd2, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 84; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 84; end
        default: begin in_idle_pct = 16; out_stall_pct = 16; end
      endcase
      while (counted < 170 * (ph + 1)) random_block();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_block_rms_level_meter OK");
    end else begin
      $display("tb_block_rms_level_meter NOT OK");
    end
    $finish;
  end

endmodule
